>>> rtl/core/adpe_pkg.sv
// ----------------------------------------------------------------------------
// adpe_pkg
// Shared types and constants for the data-processing execute unit: opcode
// encoding, flag and result structures, legality constants.
// ----------------------------------------------------------------------------
package adpe_pkg;

  localparam int unsigned RegCount = 16;
  localparam int unsigned RegAw    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [5:0] LegalTop = 6'b111000;

  typedef enum logic [3:0] {
    OpAnd = 4'h0,
    OpEor = 4'h1,
    OpSub = 4'h2,
    OpRsb = 4'h3,
    OpAdd = 4'h4,
    OpAdc = 4'h5,
    OpSbc = 4'h6,
    OpRsc = 4'h7,
    OpTst = 4'h8,
    OpTeq = 4'h9,
    OpCmp = 4'hA,
    OpCmn = 4'hB,
    OpOrr = 4'hC,
    OpMov = 4'hD,
    OpBic = 4'hE,
    OpMvn = 4'hF
  } op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic               we;
    logic [DataW-1:0]   value;
    flags_t             flags;
    logic               illegal;
  } alu_res_t;

endpackage

>>> rtl/core/arm_data_processing_execute_unit.sv
// ----------------------------------------------------------------------------
// arm_data_processing_execute_unit
// Execute stage for ARM data-processing words with a 16 x 32 register file
// and NZCV flags.
// ----------------------------------------------------------------------------
// One instruction word is accepted every cycle while the input is not
// stalled. Its result word passes through the read-data register of the
// register file, filled at the accepting edge, and then the output register,
// filled with the ALU result when the word leaves the ALU stage. The register
// file sits in two synchronous RAM copies, one per source operand, both
// written with each result; a read at the same edge as the write of the
// previous word takes the value from a forwarding register. Flags are kept
// in flip-flops and are current for every word. After reset all 16 registers
// read as zero through per-entry valid bits, so no clearing pass is needed.
// An output stall holds the word in the ALU stage and stalls the input.
module arm_data_processing_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_instruction_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_write_enable_o,
  output logic [3:0]  out_dest_index_o,
  output logic [31:0] out_dest_value_o,
  output logic        out_flag_n_o,
  output logic        out_flag_z_o,
  output logic        out_flag_c_o,
  output logic        out_flag_v_o,
  output logic        out_illegal_o
);

  logic                                s1_valid_q, s1_valid_d;
  logic [adpe_pkg::DataW-1:0]          s1_word_q;
  logic                                rn_valid_q, rm_valid_q;
  logic [adpe_pkg::RegCount-1:0]       reg_valid_q, reg_valid_d;
  adpe_pkg::flags_t                    flags_q, flags_d;
  logic                                fwd_we_q;
  logic [adpe_pkg::RegAw-1:0]          fwd_idx_q;
  logic [adpe_pkg::DataW-1:0]          fwd_val_q;
  logic                                out_valid_q, out_valid_d;
  logic                                accept;
  logic                                s1_adv;
  logic                                wr_en;
  logic [adpe_pkg::RegAw-1:0]          rn_idx, rm_idx, rd_idx;
  logic [adpe_pkg::RegAw-1:0]          in_rn, in_rm;
  logic [adpe_pkg::DataW-1:0]          rdata_a, rdata_b;
  logic [adpe_pkg::DataW-1:0]          op_a, op_b;
  adpe_pkg::alu_res_t                  res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_rn  = in_instruction_word_i[19:16];
  assign in_rm  = in_instruction_word_i[3:0];
  assign rn_idx = s1_word_q[19:16];
  assign rm_idx = s1_word_q[3:0];
  assign rd_idx = s1_word_q[15:12];

  adpe_ram #(
    .Width (adpe_pkg::DataW),
    .Depth (adpe_pkg::RegCount)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (rd_idx),
    .wdata_i (res.value),
    .re_i    (accept),
    .raddr_i (in_rn),
    .rdata_o (rdata_a)
  );

  adpe_ram #(
    .Width (adpe_pkg::DataW),
    .Depth (adpe_pkg::RegCount)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (rd_idx),
    .wdata_i (res.value),
    .re_i    (accept),
    .raddr_i (in_rm),
    .rdata_o (rdata_b)
  );

  // forwarding of the latest write (this covers the write made at the read edge), else ram or reset zero
  always_comb begin
    if (fwd_we_q && (fwd_idx_q == rn_idx)) begin
      op_a = fwd_val_q;
    end else begin
      op_a = rn_valid_q ? rdata_a : '0;
    end
    if (fwd_we_q && (fwd_idx_q == rm_idx)) begin
      op_b = fwd_val_q;
    end else begin
      op_b = rm_valid_q ? rdata_b : '0;
    end
  end

  adpe_alu u_alu (
    .word_i    (s1_word_q),
    .rn_data_i (op_a),
    .rm_data_i (op_b),
    .flags_i   (flags_q),
    .res_o     (res)
  );

  assign wr_en = s1_adv && res.we;

  always_comb begin
    s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    reg_valid_d = reg_valid_q;
    if (wr_en) begin
      reg_valid_d[rd_idx] = 1'b1;
    end
    flags_d     = s1_adv ? res.flags : flags_q;
    out_valid_d = s1_adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      reg_valid_q <= '0;
      flags_q     <= '0;
      fwd_we_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      reg_valid_q <= reg_valid_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        fwd_we_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q  <= in_instruction_word_i;
      rn_valid_q <= reg_valid_q[in_rn];
      rm_valid_q <= reg_valid_q[in_rm];
    end
    if (wr_en) begin
      fwd_idx_q <= rd_idx;
      fwd_val_q <= res.value;
    end
    if (s1_adv) begin
      out_write_enable_o <= res.we;
      out_dest_index_o   <= rd_idx;
      out_dest_value_o   <= res.value;
      out_flag_n_o       <= res.flags.n;
      out_flag_z_o       <= res.flags.z;
      out_flag_c_o       <= res.flags.c;
      out_flag_v_o       <= res.flags.v;
      out_illegal_o      <= res.illegal;
    end
  end

  assign out_valid_o = out_valid_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty alu stage");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(flags_q))
    else $error("flags changed without a retiring word");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("retired word not presented at output");

  a_illegal_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_illegal_o) |-> (!out_write_enable_o && out_dest_value_o == '0))
    else $error("illegal word produced a write or a value");

endmodule

>>> rtl/core/adpe_ram.sv
// ----------------------------------------------------------------------------
// adpe_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module adpe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/adpe_alu.sv
// ----------------------------------------------------------------------------
// adpe_alu
// Legality check, opcode decode, 32-bit ALU and NZCV flag update for one
// data-processing word.
// ----------------------------------------------------------------------------
module adpe_alu (
  input  logic [adpe_pkg::DataW-1:0] word_i,
  input  logic [adpe_pkg::DataW-1:0] rn_data_i,
  input  logic [adpe_pkg::DataW-1:0] rm_data_i,
  input  adpe_pkg::flags_t           flags_i,
  output adpe_pkg::alu_res_t         res_o
);

  always_comb begin
    logic                        imm;
    logic                        set_flags;
    logic                        legal;
    logic                        arith;
    logic                        writes;
    adpe_pkg::op_e               op;
    logic [adpe_pkg::DataW-1:0]  a;
    logic [adpe_pkg::DataW-1:0]  b;
    logic [adpe_pkg::DataW-1:0]  x;
    logic [adpe_pkg::DataW-1:0]  y;
    logic                        cin;
    logic [adpe_pkg::DataW:0]    sum;
    logic [adpe_pkg::DataW-1:0]  result;
    logic                        ovf;
    adpe_pkg::flags_t            nf;

    imm       = word_i[25];
    set_flags = word_i[20];
    op        = adpe_pkg::op_e'(word_i[24:21]);
    legal     = (word_i[31:26] == adpe_pkg::LegalTop) &&
                (imm ? (word_i[11:8] == 4'd0) : (word_i[11:4] == 8'd0));
    a         = rn_data_i;
    b         = imm ? {24'd0, word_i[7:0]} : rm_data_i;

    x     = a;
    y     = b;
    cin   = 1'b0;
    arith = 1'b1;
    case (op)
      adpe_pkg::OpSub, adpe_pkg::OpCmp: begin
        y   = ~b;
        cin = 1'b1;
      end
      adpe_pkg::OpRsb: begin
        x   = b;
        y   = ~a;
        cin = 1'b1;
      end
      adpe_pkg::OpAdc: begin
        cin = flags_i.c;
      end
      adpe_pkg::OpSbc: begin
        y   = ~b;
        cin = flags_i.c;
      end
      adpe_pkg::OpRsc: begin
        x   = b;
        y   = ~a;
        cin = flags_i.c;
      end
      adpe_pkg::OpAdd, adpe_pkg::OpCmn: begin
        cin = 1'b0;
      end
      default: begin
        arith = 1'b0;
      end
    endcase

    sum = {1'b0, x} + {1'b0, y} + {{adpe_pkg::DataW{1'b0}}, cin};
    ovf = (~(x[adpe_pkg::DataW-1] ^ y[adpe_pkg::DataW-1])) &
          (x[adpe_pkg::DataW-1] ^ sum[adpe_pkg::DataW-1]);

    case (op)
      adpe_pkg::OpAnd, adpe_pkg::OpTst: result = a & b;
      adpe_pkg::OpEor, adpe_pkg::OpTeq: result = a ^ b;
      adpe_pkg::OpOrr:                  result = a | b;
      adpe_pkg::OpMov:                  result = b;
      adpe_pkg::OpBic:                  result = a & ~b;
      adpe_pkg::OpMvn:                  result = ~b;
      default:                          result = sum[adpe_pkg::DataW-1:0];
    endcase

    writes = !((op == adpe_pkg::OpTst) || (op == adpe_pkg::OpTeq) ||
               (op == adpe_pkg::OpCmp) || (op == adpe_pkg::OpCmn));

    nf = flags_i;
    if (legal && set_flags) begin
      nf.n = result[adpe_pkg::DataW-1];
      nf.z = (result == '0);
      if (arith) begin
        nf.c = sum[adpe_pkg::DataW];
        nf.v = ovf;
      end
    end

    res_o.we      = legal && writes;
    res_o.value   = legal ? result : '0;
    res_o.flags   = nf;
    res_o.illegal = !legal;
  end

endmodule
